// File: hw/rtl/afc_pkg.sv
// Shared types, widths and codes of the frustum culling pipeline.
package afc_pkg;

  // Default number of planes held by the block.
  localparam int unsigned PLANE_COUNT_DEF = 6;

  // Field widths of one input word.
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned NORMAL_W = 16;
  localparam int unsigned COORD_W  = 32;

  // Packed stream widths.
  localparam int unsigned IN_FIELDS_W = IDX_W + 3 * NORMAL_W + 7 * COORD_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 8;

  // Arithmetic widths (all signed, terms carry 30 fraction bits).
  localparam int unsigned SUM_W   = COORD_W + 1;         // min+max, max-min
  localparam int unsigned MAG_W   = NORMAL_W + 1;        // |n| incl. sign bit
  localparam int unsigned PROD_W  = MAG_W + SUM_W;       // one product
  localparam int unsigned AXIS_W  = PROD_W + 1;          // two products
  localparam int unsigned OFFT_W  = COORD_W + 15;        // d * 2^15
  localparam int unsigned PAIR_W  = AXIS_W + 2;          // two axis terms
  localparam int unsigned ACC_W   = PAIR_W + 1;          // full plane sum

  typedef logic signed [NORMAL_W-1:0] normal_t;
  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Kind of an input word, carried in tuser.
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TEST = 1'b1
  } mode_e;

  // Advance strobes of the per-plane pipeline stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

// File: hw/rtl/afc_plane_lane.sv
// One plane: its stored normal and offset, and the four-stage signed test.
module afc_plane_lane (
  input  logic               clk_i,
  input  logic               we_i,
  input  afc_pkg::normal_t   normal_x_i,
  input  afc_pkg::normal_t   normal_y_i,
  input  afc_pkg::normal_t   normal_z_i,
  input  afc_pkg::coord_t    plane_offset_i,
  input  afc_pkg::sum_t      box_sum_i [3],
  input  afc_pkg::sum_t      box_diff_i [3],
  input  afc_pkg::stage_en_t en_i,
  output logic               neg_o
);
  import afc_pkg::*;

  normal_t                  normal_q [3];
  coord_t                   offset_q;

  logic signed [MAG_W-1:0]  mag [3];
  logic signed [PROD_W-1:0] prod_c_q [3];
  logic signed [PROD_W-1:0] prod_e_q [3];
  logic signed [OFFT_W-1:0] offt2_q;
  logic signed [AXIS_W-1:0] axis_q [3];
  logic signed [OFFT_W-1:0] offt3_q;
  logic signed [PAIR_W-1:0] pair_a_q;
  logic signed [PAIR_W-1:0] pair_b_q;
  logic signed [ACC_W-1:0]  acc;
  logic                     neg_q;

  // Plane store, written when a load word leaves the first stage.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      normal_q[0] <= normal_x_i;
      normal_q[1] <= normal_y_i;
      normal_q[2] <= normal_z_i;
      offset_q    <= plane_offset_i;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = normal_q[a][NORMAL_W-1] ? -MAG_W'(normal_q[a]) : MAG_W'(normal_q[a]);
    end
  end

  // Stage 2: products of the center and extent terms.
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int a = 0; a < 3; a++) begin
        prod_c_q[a] <= PROD_W'(normal_q[a]) * PROD_W'(box_sum_i[a]);
        prod_e_q[a] <= PROD_W'(mag[a]) * PROD_W'(box_diff_i[a]);
      end
      offt2_q <= {offset_q, 15'd0};
    end
  end

  // Stage 3: one term per axis.
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int a = 0; a < 3; a++) begin
        axis_q[a] <= AXIS_W'(prod_c_q[a]) + AXIS_W'(prod_e_q[a]);
      end
      offt3_q <= offt2_q;
    end
  end

  // Stage 4: pairwise sums.
  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      pair_a_q <= PAIR_W'(axis_q[0]) + PAIR_W'(axis_q[1]);
      pair_b_q <= PAIR_W'(axis_q[2]) + PAIR_W'(offt3_q);
    end
  end

  // Stage 5: final sum, keep its sign.
  assign acc = ACC_W'(pair_a_q) + ACC_W'(pair_b_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      neg_q <= acc[ACC_W-1];
    end
  end

  assign neg_o = neg_q;

endmodule

// File: hw/rtl/aabb_frustum_cull.sv
// Top level of the axis-aligned box frustum culling pipeline, default 6 planes.
// The block keeps PLANE_COUNT planes (normal in Q2.14, offset in Q16.16) and
// streams boxes through an exact fixed-point test. A word with tuser = 0 loads
// the plane named by its plane index (an index of PLANE_COUNT or more is
// dropped) and returns nothing; a word with tuser = 1 carries a box and
// returns one word whose bit 0 is 1 when the box lies inside or crosses every
// plane, 0 when it lies wholly behind any one of them. The test evaluated is
// n.(min+max) + |n|.(max-min) + 2d < 0 per plane, with 30 fraction bits and no
// rounding. One word is accepted every cycle while no stall holds the input;
// a box passes the input register, then multiply, axis add, pair add, final
// add and output register, and all planes are evaluated in parallel lanes.
// A load takes effect for every box accepted after it. Backpressure from the
// result side stalls only the stages that are full; bubbles close up, so a
// word is never lost or repeated. Planes must be loaded before use.
module aabb_frustum_cull #(
  parameter int unsigned PLANE_COUNT = afc_pkg::PLANE_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input words.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low bit up: plane_index[3], normal_x[16], normal_y[16],
  // normal_z[16], plane_offset[32], min_x[32], min_y[32], min_z[32],
  // max_x[32], max_y[32], max_z[32], zero pad to 280 bits.
  input  logic [afc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: mode (0 load plane, 1 test box).
  input  logic [afc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // Result words.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low bit up: visible[1], zero pad to 8 bits.
  output logic [afc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import afc_pkg::*;

  // Unpack the input word.
  logic [IDX_W-1:0] in_idx;
  normal_t          in_nx, in_ny, in_nz;
  coord_t           in_off;
  coord_t           in_lo [3];
  coord_t           in_hi [3];
  mode_e            in_mode;

  assign in_mode = mode_e'(s_axis_tuser[0]);
  assign in_idx  = s_axis_tdata[2:0];
  assign in_nx   = s_axis_tdata[18:3];
  assign in_ny   = s_axis_tdata[34:19];
  assign in_nz   = s_axis_tdata[50:35];
  assign in_off  = s_axis_tdata[82:51];
  assign in_lo[0] = s_axis_tdata[114:83];
  assign in_lo[1] = s_axis_tdata[146:115];
  assign in_lo[2] = s_axis_tdata[178:147];
  assign in_hi[0] = s_axis_tdata[210:179];
  assign in_hi[1] = s_axis_tdata[242:211];
  assign in_hi[2] = s_axis_tdata[274:243];

  // Stage 1 holds the accepted word with box sums and extents formed.
  logic             s1_valid_q;
  mode_e            s1_mode_q;
  logic [IDX_W-1:0] s1_idx_q;
  normal_t          s1_nx_q, s1_ny_q, s1_nz_q;
  coord_t           s1_off_q;
  sum_t             s1_sum_q [3];
  sum_t             s1_diff_q [3];

  // Valid bits of the lane stages and of the output register.
  logic s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, out_valid_q;
  logic visible_q;

  // Advance strobes: a stage moves when it is empty or its successor moves.
  logic      en_out, en1;
  stage_en_t en;

  assign en_out = !out_valid_q || m_axis_tready;
  assign en.s5  = !s5_valid_q || en_out;
  assign en.s4  = !s4_valid_q || en.s5;
  assign en.s3  = !s3_valid_q || en.s4;
  assign en.s2  = !s2_valid_q || en.s3;
  assign en1    = !s1_valid_q || en.s2;

  assign s_axis_tready = en1;

  // Stage 1 payload: form min+max and max-min per axis.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_mode_q <= in_mode;
      s1_idx_q  <= in_idx;
      s1_nx_q   <= in_nx;
      s1_ny_q   <= in_ny;
      s1_nz_q   <= in_nz;
      s1_off_q  <= in_off;
      for (int a = 0; a < 3; a++) begin
        s1_sum_q[a]  <= SUM_W'(in_lo[a]) + SUM_W'(in_hi[a]);
        s1_diff_q[a] <= SUM_W'(in_hi[a]) - SUM_W'(in_lo[a]);
      end
    end
  end

  // A load word writes its plane as it leaves stage 1; only tests go on.
  logic load_go;
  assign load_go = en.s2 && s1_valid_q && (s1_mode_q == MODE_LOAD);

  logic [PLANE_COUNT-1:0] neg;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    afc_plane_lane u_lane (
      .clk_i          (clk_i),
      .we_i           (load_go && ({1'b0, s1_idx_q} == (IDX_W + 1)'(p))),
      .normal_x_i     (s1_nx_q),
      .normal_y_i     (s1_ny_q),
      .normal_z_i     (s1_nz_q),
      .plane_offset_i (s1_off_q),
      .box_sum_i      (s1_sum_q),
      .box_diff_i     (s1_diff_q),
      .en_i           (en),
      .neg_o          (neg[p])
    );
  end

  // Result register: visible unless some plane came out negative.
  always_ff @(posedge clk_i) begin
    if (en_out && s5_valid_q) begin
      visible_q <= ~|neg;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    s1_valid_q  <= s_axis_tvalid;
      if (en.s2)  s2_valid_q  <= s1_valid_q && (s1_mode_q == MODE_TEST);
      if (en.s3)  s3_valid_q  <= s2_valid_q;
      if (en.s4)  s4_valid_q  <= s3_valid_q;
      if (en.s5)  s5_valid_q  <= s4_valid_q;
      if (en_out) out_valid_q <= s5_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, visible_q};

`ifndef SYNTHESIS
  // A load word never reaches the lanes as a test.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_go) |=> !s2_valid_q)
    else $error("load word entered the test pipeline");

  // With every stage full and the output stalled, hold off the input.
  a_full_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && s5_valid_q && s4_valid_q && s3_valid_q
     && s2_valid_q && s1_valid_q) |-> !s_axis_tready)
    else $error("input accepted into a full, stalled pipeline");

  // A taken result with nothing behind it leaves the output empty.
  a_drain_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready && !s5_valid_q) |=> !out_valid_q)
    else $error("result repeated after it was taken");

  // A stalled final stage keeps its result in place.
  a_s5_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_valid_q && !en.s5) |=> (s5_valid_q && $stable(neg)))
    else $error("stage five changed while stalled");
`endif

endmodule
